// ===== src/dwst_pkg.sv =====
// ----------------------------------------------------------------------------
// dwst_pkg
// Shared types and constants for the debug watchpoint slot table.
// ----------------------------------------------------------------------------
package dwst_pkg;

  localparam int unsigned MaxSlots  = 16;
  localparam int unsigned SlotIdxW  = 4;
  localparam int unsigned CountW    = 5;
  localparam int unsigned AddrW     = 64;
  localparam int unsigned LenW      = 32;
  localparam int unsigned DirW      = 2;
  localparam int unsigned SelW      = 8;
  localparam int unsigned ExpW      = 5;

  localparam logic [CountW-1:0] SlotCountRst = CountW'(MaxSlots);

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_FULL      = 3'd2,
    ST_EXISTS    = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SLOT_NONE = 2'd0,
    SLOT_SCAN = 2'd1,
    SLOT_FREE = 2'd2
  } slot_sel_e;

  // controller -> datapath
  typedef struct packed {
    logic      load_req;
    logic      clear_all;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      set_res;
    status_e   res_status;
    slot_sel_e res_slot;
    logic      res_hit;
    logic      write_entry;
    logic      free_entry;
    logic      out_load;
  } dwst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_e mode;
    logic  region_ok;
    logic  table_full;
    logic  scan_none;
    logic  match;
    logic  scan_last;
    logic  out_free;
  } dwst_stat_t;

endpackage

// ===== src/dwst_req_if.sv =====
// ----------------------------------------------------------------------------
// dwst_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface dwst_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] address;
  logic [31:0] length;
  logic [1:0]  direction;

  modport source (output valid, mode, address, length, direction, input ready);
  modport sink   (input valid, mode, address, length, direction, output ready);
endinterface

// ===== src/dwst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dwst_rsp_if
// Response channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface dwst_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] slot_index;
  logic [1:0] hit_direction;
  logic [7:0] hit_byte_select;
  logic [4:0] hit_mask_bits;
  logic       hit_enabled;

  modport source (output valid, status, slot_index, hit_direction, hit_byte_select,
                  hit_mask_bits, hit_enabled, input ready);
  modport sink   (input valid, status, slot_index, hit_direction, hit_byte_select,
                  hit_mask_bits, hit_enabled, output ready);
endinterface

// ===== src/debug_watchpoint_slot_table.sv =====
// ----------------------------------------------------------------------------
// debug_watchpoint_slot_table
// Watchpoint slot table with add, remove, remove-all and covering lookup.
// ----------------------------------------------------------------------------
// Usage:
//  - req_i carries one request transaction (mode, address, length, direction);
//    rsp_o returns exactly one result transaction per request, in order.
//  - cfg_we_i/cfg_wdata_i write slot_count; write it only while idle.
//  - One request at a time. Remove-all, invalid region, table full or no
//    usable slot are answered from the check alone, without a slot scan;
//    otherwise the scan runs over slots 0 to j, j = the slot that hits, or the
//    last usable slot when nothing hits; j <= min(slot_count, 16) - 1. The
//    scan compares one entry per cycle through the shared exact/cover compare
//    unit. The next request is taken at the first edge at which rsp_o can be
//    taken.
//  - req_i.ready is high only while the sequencer is idle. A finished result
//    sits in the output register, so a new request is accepted while rsp_o
//    is stalled; that request's result then waits until the register drains.
//  - Reset (rst_ni low, asynchronous) frees every slot, restores slot_count
//    to 16 and empties the output register. Entry contents are not cleared;
//    only the used bits gate them.
// ----------------------------------------------------------------------------
module debug_watchpoint_slot_table
  import dwst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  dwst_req_if.sink          req_i,
  dwst_rsp_if.source        rsp_o
);

  dwst_cmd_t  cmd;
  dwst_stat_t stat;

  // sequencer: idle -> check -> scan -> hand result to output register
  dwst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // table, compare unit and result registers
  dwst_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .req_mode_i            (req_i.mode),
    .req_address_i         (req_i.address),
    .req_length_i          (req_i.length),
    .req_direction_i       (req_i.direction),
    .rsp_valid_o           (rsp_o.valid),
    .rsp_ready_i           (rsp_o.ready),
    .rsp_status_o          (rsp_o.status),
    .rsp_slot_index_o      (rsp_o.slot_index),
    .rsp_hit_direction_o   (rsp_o.hit_direction),
    .rsp_hit_byte_select_o (rsp_o.hit_byte_select),
    .rsp_hit_mask_bits_o   (rsp_o.hit_mask_bits),
    .rsp_hit_enabled_o     (rsp_o.hit_enabled),
    .cmd_i                 (cmd),
    .stat_o                (stat)
  );

endmodule

// ===== src/dwst_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwst_ctrl
// Request sequencer: check, slot scan, result hand-off.
// ----------------------------------------------------------------------------
module dwst_ctrl
  import dwst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  dwst_stat_t stat_i,
  output dwst_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.cnt_clr = 1'b1;
        state_d       = S_DONE;
        if (stat_i.mode == MODE_CLEAR) begin
          cmd_o.clear_all  = 1'b1;
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_OK;
        end else if ((stat_i.mode == MODE_ADD || stat_i.mode == MODE_REMOVE) &&
                     !stat_i.region_ok) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_INVALID;
        end else if (stat_i.mode == MODE_ADD && stat_i.table_full) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_FULL;
        end else if (stat_i.scan_none) begin
          // no usable slot: remove and lookup miss
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.match) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_slot = SLOT_SCAN;
          state_d        = S_DONE;
          unique case (stat_i.mode)
            MODE_ADD:    cmd_o.res_status = ST_EXISTS;
            MODE_REMOVE: begin
              cmd_o.res_status = ST_OK;
              cmd_o.free_entry = 1'b1;
            end
            default: begin
              cmd_o.res_status = ST_OK;
              cmd_o.res_hit    = 1'b1;
            end
          endcase
        end else if (stat_i.scan_last) begin
          cmd_o.set_res = 1'b1;
          state_d       = S_DONE;
          if (stat_i.mode == MODE_ADD) begin
            cmd_o.write_entry = 1'b1;
            cmd_o.res_status  = ST_OK;
            cmd_o.res_slot    = SLOT_FREE;
          end else begin
            cmd_o.res_status = ST_NOT_FOUND;
          end
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== src/dwst_datapath.sv =====
// ----------------------------------------------------------------------------
// dwst_datapath
// Slot table, request registers, shared slot compare and result registers.
// ----------------------------------------------------------------------------
module dwst_datapath
  import dwst_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CountW-1:0]   cfg_wdata_i,
  input  logic [1:0]          req_mode_i,
  input  logic [AddrW-1:0]    req_address_i,
  input  logic [LenW-1:0]     req_length_i,
  input  logic [DirW-1:0]     req_direction_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output logic [2:0]          rsp_status_o,
  output logic [SlotIdxW-1:0] rsp_slot_index_o,
  output logic [DirW-1:0]     rsp_hit_direction_o,
  output logic [SelW-1:0]     rsp_hit_byte_select_o,
  output logic [ExpW-1:0]     rsp_hit_mask_bits_o,
  output logic                rsp_hit_enabled_o,
  input  dwst_cmd_t           cmd_i,
  output dwst_stat_t          stat_o
);

  function automatic logic [2:0] low_bit8(input logic [SelW-1:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = SelW - 1; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  function automatic logic [3:0] pop8(input logic [SelW-1:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < SelW; i++) n = n + 4'(v[i]);
    return n;
  endfunction

  function automatic logic [ExpW-1:0] log2_pow2(input logic [LenW-1:0] v);
    logic [ExpW-1:0] e;
    e = '0;
    for (int i = 0; i < LenW; i++) begin
      if (v[i]) e = e | ExpW'(i);
    end
    return e;
  endfunction

  // request registers
  logic [1:0]        mode_q;
  logic [AddrW-1:0]  addr_q;
  logic [LenW-1:0]   len_q;
  logic [DirW-1:0]   dir_q;
  logic [CountW-1:0] slot_count_q;

  // slot table
  logic [MaxSlots-1:0] used_q;
  logic [AddrW-1:0]    base_q  [MaxSlots];
  logic [SelW-1:0]     bytes_q [MaxSlots];
  logic [ExpW-1:0]     exp_q   [MaxSlots];
  logic [DirW-1:0]     sdir_q  [MaxSlots];

  logic [SlotIdxW-1:0] cnt_q;

  // pending result
  status_e             res_status_q;
  logic [SlotIdxW-1:0] res_slot_q;
  logic [DirW-1:0]     res_hdir_q;
  logic [SelW-1:0]     res_hbytes_q;
  logic [ExpW-1:0]     res_hexp_q;
  logic                res_hen_q;

  // output register
  logic                out_valid_q;
  logic [2:0]          out_status_q;
  logic [SlotIdxW-1:0] out_slot_q;
  logic [DirW-1:0]     out_hdir_q;
  logic [SelW-1:0]     out_hbytes_q;
  logic [ExpW-1:0]     out_hexp_q;
  logic                out_hen_q;

  logic [CountW-1:0]   n_act;
  logic                free_found;
  logic [SlotIdxW-1:0] free_idx;
  logic                big_len, region_ok;
  logic [ExpW-1:0]     len_exp;
  logic [15:0]         sel_full;
  logic [SelW-1:0]     new_sel;

  logic [AddrW-1:0] e_base;
  logic [SelW-1:0]  e_bytes;
  logic [ExpW-1:0]  e_exp;
  logic [DirW-1:0]  e_dir;
  logic [AddrW-1:0] e_start, keep;
  logic [LenW-1:0]  e_size;
  logic             exact_hit, cover_hit;

  assign n_act = (slot_count_q > CountW'(MaxSlots)) ? CountW'(MaxSlots) : slot_count_q;

  // lowest free slot below the active count
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MaxSlots - 1; i >= 0; i--) begin
      if (CountW'(i) < n_act && !used_q[i]) begin
        free_found = 1'b1;
        free_idx   = SlotIdxW'(i);
      end
    end
  end

  // region check
  assign big_len = len_q > LenW'(8);
  always_comb begin
    if (len_q == '0 || len_q > 32'h8000_0000) begin
      region_ok = 1'b0;
    end else if (big_len) begin
      region_ok = ((len_q & (len_q - LenW'(1))) == '0) && (len_q >= LenW'(16)) &&
                  ((addr_q[LenW-1:0] & (len_q - LenW'(1))) == '0);
    end else begin
      // first and last byte inside one doubleword
      region_ok = ({1'b0, addr_q[2:0]} + len_q[3:0]) <= 4'd8;
    end
  end

  assign len_exp  = log2_pow2(len_q);
  assign sel_full = ((16'd1 << len_q[3:0]) - 16'd1) << addr_q[2:0];
  assign new_sel  = sel_full[SelW-1:0];

  // entry under scan
  assign e_base  = base_q[cnt_q];
  assign e_bytes = bytes_q[cnt_q];
  assign e_exp   = exp_q[cnt_q];
  assign e_dir   = sdir_q[cnt_q];

  always_comb begin
    if (e_exp != '0) begin
      e_start = e_base;
      e_size  = LenW'(1) << e_exp;
      keep    = ~((AddrW'(1) << e_exp) - AddrW'(1));
    end else begin
      e_start = {e_base[AddrW-1:3], low_bit8(e_bytes)};
      e_size  = LenW'(pop8(e_bytes));
      keep    = ~AddrW'(7);
    end
  end

  assign exact_hit = (addr_q == e_start) && (dir_q == e_dir) && (e_size == len_q);
  assign cover_hit = ((addr_q & keep) == e_base) && ((dir_q & e_dir) != '0);

  assign stat_o.mode       = mode_e'(mode_q);
  assign stat_o.region_ok  = region_ok;
  assign stat_o.table_full = !free_found;
  assign stat_o.scan_none  = (n_act == '0);
  assign stat_o.match      = used_q[cnt_q] &&
                             ((mode_e'(mode_q) == MODE_LOOKUP) ? cover_hit : exact_hit);
  assign stat_o.scan_last  = ({1'b0, cnt_q} == n_act - CountW'(1));
  assign stat_o.out_free   = !out_valid_q || rsp_ready_i;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SlotCountRst;
      used_q       <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) slot_count_q <= cfg_wdata_i;
      if (cmd_i.clear_all) begin
        used_q <= '0;
      end else if (cmd_i.write_entry) begin
        used_q[free_idx] <= 1'b1;
      end else if (cmd_i.free_entry) begin
        used_q[cnt_q] <= 1'b0;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + SlotIdxW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      mode_q <= req_mode_i;
      addr_q <= req_address_i;
      len_q  <= req_length_i;
      dir_q  <= req_direction_i;
    end
    if (cmd_i.write_entry) begin
      sdir_q[free_idx] <= dir_q;
      if (big_len) begin
        base_q[free_idx]  <= addr_q;
        bytes_q[free_idx] <= '1;
        exp_q[free_idx]   <= len_exp;
      end else begin
        base_q[free_idx]  <= {addr_q[AddrW-1:3], 3'b000};
        bytes_q[free_idx] <= new_sel;
        exp_q[free_idx]   <= '0;
      end
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      case (cmd_i.res_slot)
        SLOT_SCAN: res_slot_q <= cnt_q;
        SLOT_FREE: res_slot_q <= free_idx;
        default:   res_slot_q <= '0;
      endcase
      res_hdir_q   <= cmd_i.res_hit ? e_dir   : '0;
      res_hbytes_q <= cmd_i.res_hit ? e_bytes : '0;
      res_hexp_q   <= cmd_i.res_hit ? e_exp   : '0;
      res_hen_q    <= cmd_i.res_hit;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_hdir_q   <= res_hdir_q;
      out_hbytes_q <= res_hbytes_q;
      out_hexp_q   <= res_hexp_q;
      out_hen_q    <= res_hen_q;
    end
  end

  assign rsp_valid_o           = out_valid_q;
  assign rsp_status_o          = out_status_q;
  assign rsp_slot_index_o      = out_slot_q;
  assign rsp_hit_direction_o   = out_hdir_q;
  assign rsp_hit_byte_select_o = out_hbytes_q;
  assign rsp_hit_mask_bits_o   = out_hexp_q;
  assign rsp_hit_enabled_o     = out_hen_q;

endmodule
